// ===== hw/rtl/ctl_pkg.sv =====
`default_nettype none
package ctl_pkg;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_NAME   = 4'd1,
    M_CNAME  = 4'd2,
    M_INT    = 4'd3,
    M_STR    = 4'd4,
    M_CMT    = 4'd5,
    M_EOL    = 4'd6,
    M_EOLCMT = 4'd7
  } lex_mode_e;

  typedef enum logic [1:0] {
    P_NONE = 2'd0,
    P_EQ   = 2'd1,
    P_BANG = 2'd2,
    P_PLUS = 2'd3
  } pend_e;

  localparam logic [4:0] K_EOL        = 5'd0;
  localparam logic [4:0] K_ASSIGN     = 5'd1;
  localparam logic [4:0] K_APPEND     = 5'd2;
  localparam logic [4:0] K_ARRASSIGN  = 5'd3;
  localparam logic [4:0] K_EQ         = 5'd4;
  localparam logic [4:0] K_MATCH      = 5'd5;
  localparam logic [4:0] K_NE         = 5'd6;
  localparam logic [4:0] K_NOMATCH    = 5'd7;
  localparam logic [4:0] K_PLUS       = 5'd8;
  localparam logic [4:0] K_COMMA      = 5'd9;
  localparam logic [4:0] K_STRING     = 5'd10;
  localparam logic [4:0] K_INTEGER    = 5'd11;
  localparam logic [4:0] K_LKEY       = 5'd12;
  localparam logic [4:0] K_CONDNAME   = 5'd13;
  localparam logic [4:0] K_DOLLAR     = 5'd14;
  localparam logic [4:0] K_LPAREN     = 5'd15;
  localparam logic [4:0] K_RPAREN     = 5'd16;
  localparam logic [4:0] K_LCURLY     = 5'd17;
  localparam logic [4:0] K_RCURLY     = 5'd18;
  localparam logic [4:0] K_LBRACKET   = 5'd19;
  localparam logic [4:0] K_RBRACKET   = 5'd20;
  localparam logic [4:0] K_KW0        = 5'd21;
  localparam logic [4:0] K_END        = 5'd25;
  localparam logic [4:0] K_ERROR      = 5'd26;

  localparam logic [3:0] E_NONE       = 4'd0;
  localparam logic [3:0] E_EQ_PAREN   = 4'd1;
  localparam logic [3:0] E_EQ_COND    = 4'd2;
  localparam logic [3:0] E_EQ_BARE    = 4'd3;
  localparam logic [3:0] E_BANG_COND  = 4'd4;
  localparam logic [3:0] E_BANG_BARE  = 4'd5;
  localparam logic [3:0] E_OPEN_STR   = 4'd6;
  localparam logic [3:0] E_COND_CHAR  = 4'd7;
  localparam logic [3:0] E_NAME_CHAR  = 4'd8;

  localparam int unsigned FW = 20;
  localparam logic [FW-1:0] LINE_SAT = '1;

  typedef struct packed {
    logic [4:0]    kind;
    logic [3:0]    error_code;
    logic [FW-1:0] start_offset;
    logic [FW-1:0] span_length;
    logic [FW-1:0] line_number;
    logic          last_result;
  } tok_t;

  // keyword character at position n (0 beyond length)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] n);
    logic [8*13-1:0] s;
    case (k)
      2'd0:    s = {"include", 48'd0};
      2'd1:    s = {"include", "_shell"};
      2'd2:    s = {"global", 56'd0};
      default: s = {"else", 72'd0};
    endcase
    kw_char = (n > 4'd12) ? 8'd0 : s[8*(12-n) +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    kw_len = 4'd7;
      2'd1:    kw_len = 4'd13;
      2'd2:    kw_len = 4'd6;
      default: kw_len = 4'd4;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_namech(input logic [7:0] c);
    is_namech = is_alpha(c) || is_digit(c) || c == "." || c == "_" || c == "-";
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ctl_byte_if.sv =====
`default_nettype none
interface ctl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ctl_tok_if.sv =====
`default_nettype none
interface ctl_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [3:0]  error_code;
  logic [19:0] start_offset;
  logic [19:0] span_length;
  logic [19:0] line_number;
  logic        last_result;
  modport source (output valid, kind, error_code, start_offset, span_length,
                  line_number, last_result, input ready);
  modport sink   (input valid, kind, error_code, start_offset, span_length,
                  line_number, last_result, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ctl_core.sv =====
`default_nettype none
// Lexer state update: one byte in, up to three tokens out, all combinational
// from the registered state; state registers update when the beat is taken.
module ctl_core #(
  parameter int unsigned OFFSET_BITS     = 20,
  parameter int unsigned MAX_PAREN_DEPTH = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output ctl_pkg::tok_t [2:0]   tok_o,
  output logic [1:0]            cnt_o
);
  import ctl_pkg::*;

  localparam int unsigned PDW = $clog2(MAX_PAREN_DEPTH + 1);
  localparam logic [OFFSET_BITS-1:0] OSAT = '1;
  localparam logic [PDW-1:0] PMAX = PDW'(MAX_PAREN_DEPTH);

  lex_mode_e            mode_q, mode_d;
  pend_e                pend_q, pend_d;
  logic [PDW-1:0]       depth_q, depth_d;
  logic                 cond_q, cond_d, key_q, key_d, esc_q, esc_d;
  logic [3:0]           kwm_q, kwm_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, tstart_q, tstart_d;
  logic [FW-1:0]        line_q, line_d, tline_q, tline_d;
  logic                 cr_q, cr_d, halt_q, halt_d;

  tok_t [2:0] t;
  logic [1:0] n;

  function automatic logic [OFFSET_BITS-1:0] sinc(input logic [OFFSET_BITS-1:0] v);
    sinc = (v == OSAT) ? v : v + 1'b1;
  endfunction

  function automatic logic [FW-1:0] ofs(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FW-1:0] w;
    w = {{FW{1'b0}}, v};
    ofs = w[FW-1:0];
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [OFFSET_BITS-1:0] pos, nx, span, fin;
    logic again, is_nl;
    logic [3:0] kk;
    logic [4:0] nk;
    mode_d = mode_q; pend_d = pend_q; depth_d = depth_q; cond_d = cond_q;
    key_d = key_q; esc_d = esc_q; kwm_d = kwm_q; off_d = off_q;
    tstart_d = tstart_q; line_d = line_q; tline_d = tline_q; cr_d = cr_q;
    halt_d = halt_q;
    t = '0; n = 2'd0;
    c = byte_i; pos = off_q; nx = sinc(pos);
    again = 1'b0; is_nl = (c == 8'h0a) || (c == 8'h0d);
    kk = 4'd0; nk = K_LKEY; span = '0; fin = '0;

    if (!halt_q) begin
      if (c == 8'd0) begin
        fin = pos;
      end else begin
        // ---- consume
        if (pend_q != P_NONE) begin
          pend_d = P_NONE;
          if (pend_q == P_PLUS) begin
            if (c == "=") begin
              t[n] = '{K_APPEND, E_NONE, ofs(tstart_q), ofs((nx > tstart_q) ? nx - tstart_q : '0),
                       tline_q, 1'b0}; n = n + 2'd1;
            end else begin
              t[n] = '{K_PLUS, E_NONE, ofs(tstart_q), FW'(1), tline_q, 1'b0}; n = n + 2'd1;
              again = 1'b1;
            end
          end else if (pend_q == P_EQ && depth_q != '0) begin
            if (c == ">") begin
              t[n] = '{K_ARRASSIGN, E_NONE, ofs(tstart_q),
                       ofs((nx > tstart_q) ? nx - tstart_q : '0), tline_q, 1'b0};
            end else begin
              t[n] = '{K_ERROR, E_EQ_PAREN, ofs(tstart_q), '0, tline_q, 1'b0};
              halt_d = 1'b1; mode_d = M_IDLE;
            end
            n = n + 2'd1;
          end else begin
            if (c == "=") nk = (pend_q == P_EQ) ? K_EQ : K_NE;
            else if (c == "~") nk = (pend_q == P_EQ) ? K_MATCH : K_NOMATCH;
            else nk = K_ERROR;
            if (nk == K_ERROR) begin
              t[n] = '{K_ERROR, (pend_q == P_EQ) ? E_EQ_COND : E_BANG_COND,
                       ofs(tstart_q), '0, tline_q, 1'b0};
              halt_d = 1'b1; mode_d = M_IDLE;
            end else begin
              t[n] = '{nk, E_NONE, ofs(tstart_q), ofs((nx > tstart_q) ? nx - tstart_q : '0),
                       tline_q, 1'b0};
              cond_d = 1'b0; key_d = 1'b1;
            end
            n = n + 2'd1;
          end
        end else begin
          span = (pos > tstart_q) ? pos - tstart_q : '0;
          case (mode_q)
            M_NAME: begin
              if (is_namech(c)) begin
                for (int k = 0; k < 4; k++)
                  if (kwm_q[k] && (span >= OFFSET_BITS'(kw_len(2'(k))) ||
                      kw_char(2'(k), span[3:0]) != c))
                    kwm_d[k] = 1'b0;
              end else begin
                nk = K_LKEY;
                for (int k = 3; k >= 0; k--)
                  if (kwm_q[k] && span == OFFSET_BITS'(kw_len(2'(k))))
                    nk = K_KW0 + 5'(k);
                t[n] = '{nk, E_NONE, ofs(tstart_q), ofs(span), tline_q, 1'b0};
                n = n + 2'd1; mode_d = M_IDLE; again = 1'b1;
              end
            end
            M_CNAME: begin
              if (!is_alpha(c)) begin
                t[n] = '{K_CONDNAME, E_NONE, ofs(tstart_q), ofs(span), tline_q, 1'b0};
                n = n + 2'd1; mode_d = M_IDLE; again = 1'b1;
              end
            end
            M_INT: begin
              if (!is_digit(c)) begin
                t[n] = '{K_INTEGER, E_NONE, ofs(tstart_q), ofs(span), tline_q, 1'b0};
                n = n + 2'd1; mode_d = M_IDLE; again = 1'b1;
              end
            end
            M_STR: begin
              if (esc_q && c == 8'h22) esc_d = 1'b0;
              else begin
                esc_d = (c == 8'h5c);
                if (c == 8'h22) begin
                  t[n] = '{K_STRING, E_NONE, ofs(tstart_q),
                           ofs((nx > tstart_q) ? nx - tstart_q : '0), tline_q, 1'b0};
                  n = n + 2'd1; mode_d = M_IDLE;
                end
              end
            end
            M_CMT: begin
              if (is_nl) begin
                mode_d = M_IDLE; again = 1'b1;
              end
            end
            M_EOL: begin
              if (is_nl) begin
                if (!(c == 8'h0a && cr_q) && line_q != LINE_SAT) line_d = line_q + 1'b1;
              end else if (c == "#") mode_d = M_EOLCMT;
              else if (c != " " && c != 8'h09) begin
                t[n] = '{K_EOL, E_NONE, ofs(tstart_q), ofs(span), tline_q, 1'b0};
                n = n + 2'd1; key_d = 1'b1; mode_d = M_IDLE; again = 1'b1;
              end
            end
            M_EOLCMT: begin
              if (is_nl) begin
                if (!(c == 8'h0a && cr_q) && line_q != LINE_SAT) line_d = line_q + 1'b1;
                mode_d = M_EOL;
              end
            end
            default: begin
              mode_d = M_IDLE; again = 1'b1;
            end
          endcase
        end
        // ---- dispatch (line_q is unchanged whenever again is set)
        if (again && !halt_d) begin
          tstart_d = pos; tline_d = line_q;
          nk = K_EOL; kk = 4'd0;
          case (c)
            "=": begin
              if (depth_d != '0 || cond_d) pend_d = P_EQ;
              else if (key_d) nk = K_ASSIGN;
              else kk = E_EQ_BARE;
            end
            "!": begin
              if (cond_d) pend_d = P_BANG; else kk = E_BANG_BARE;
            end
            "+": pend_d = P_PLUS;
            " ", 8'h09: ;
            8'h0d, 8'h0a: begin
              if (!(c == 8'h0a && cr_q) && line_q != LINE_SAT) line_d = line_q + 1'b1;
              if (depth_d == '0) mode_d = M_EOL;
            end
            ",": if (depth_d != '0) nk = K_COMMA;
            8'h22: begin
              mode_d = M_STR; esc_d = 1'b0;
            end
            "(": begin
              if (depth_d < PMAX) depth_d = depth_d + 1'b1;
              nk = K_LPAREN;
            end
            ")": begin
              if (depth_d != '0) depth_d = depth_d - 1'b1;
              nk = K_RPAREN;
            end
            "$": begin
              cond_d = 1'b1; key_d = 1'b0; nk = K_DOLLAR;
            end
            "{": nk = K_LCURLY;
            "}": nk = K_RCURLY;
            "[": nk = K_LBRACKET;
            "]": nk = K_RBRACKET;
            "#": mode_d = M_CMT;
            default: begin
              if (cond_d) begin
                if (is_alpha(c)) mode_d = M_CNAME; else kk = E_COND_CHAR;
              end else if (is_digit(c)) mode_d = M_INT;
              else if (is_namech(c)) begin
                mode_d = M_NAME;
                for (int k = 0; k < 4; k++)
                  kwm_d[k] = (kw_char(2'(k), 4'd0) == c);
              end else kk = E_NAME_CHAR;
            end
          endcase
          if (kk != E_NONE) begin
            t[n] = '{K_ERROR, kk, ofs(pos), '0, line_q, 1'b0};
            n = n + 2'd1; halt_d = 1'b1; mode_d = M_IDLE; pend_d = P_NONE;
          end else if (nk != K_EOL) begin
            t[n] = '{nk, E_NONE, ofs(pos), ofs(nx - pos), line_q, 1'b0};
            n = n + 2'd1;
          end
        end
        cr_d = (c == 8'h0d);
        off_d = nx;
        fin = nx;
      end
      // ---- finish
      if ((c == 8'd0 || last_i) && !halt_d) begin
        span = (fin > tstart_d) ? fin - tstart_d : '0;
        kk = E_NONE;
        if (pend_d == P_PLUS) begin
          t[n] = '{K_PLUS, E_NONE, ofs(tstart_d), FW'(1), tline_d, 1'b0}; n = n + 2'd1;
        end else if (pend_d == P_EQ)
          kk = (depth_d != '0) ? E_EQ_PAREN : (cond_d ? E_EQ_COND : E_EQ_BARE);
        else if (pend_d == P_BANG) kk = cond_d ? E_BANG_COND : E_BANG_BARE;
        else begin
          case (mode_d)
            M_NAME:  kk = E_NAME_CHAR;
            M_CNAME: kk = E_COND_CHAR;
            M_STR:   kk = E_OPEN_STR;
            M_INT: begin
              t[n] = '{K_INTEGER, E_NONE, ofs(tstart_d), ofs(span), tline_d, 1'b0};
              n = n + 2'd1;
            end
            M_EOL, M_EOLCMT: begin
              t[n] = '{K_EOL, E_NONE, ofs(tstart_d), ofs(span), tline_d, 1'b0};
              n = n + 2'd1; key_d = 1'b1;
            end
            default: ;
          endcase
        end
        if (kk != E_NONE) t[n] = '{K_ERROR, kk, ofs(tstart_d), '0, tline_d, 1'b0};
        else t[n] = '{K_END, E_NONE, ofs(fin), '0, line_d, 1'b0};
        n = n + 2'd1;
        halt_d = 1'b1; pend_d = P_NONE; mode_d = M_IDLE;
      end
      if (n != 2'd0) t[n - 2'd1].last_result = 1'b1;
    end
  end

  assign tok_o = t;
  assign cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= P_NONE; depth_q <= '0; cond_q <= 1'b0;
      key_q <= 1'b1; esc_q <= 1'b0; kwm_q <= 4'hf; off_q <= '0; tstart_q <= '0;
      line_q <= FW'(1); tline_q <= FW'(1); cr_q <= 1'b0; halt_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; pend_q <= pend_d; depth_q <= depth_d; cond_q <= cond_d;
      key_q <= key_d; esc_q <= esc_d; kwm_q <= kwm_d; off_q <= off_d;
      tstart_q <= tstart_d; line_q <= line_d; tline_q <= tline_d; cr_q <= cr_d;
      halt_q <= halt_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ctl_outq.sv =====
`default_nettype none
// Result queue: up to three tokens per byte written at once, one read per
// beat. Four-entry ring; space for a full burst is required to take a byte.
module ctl_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire ctl_pkg::tok_t [2:0] tok_i,
  input  wire logic [1:0]         cnt_i,
  output logic                    space_o,
  output logic                    valid_o,
  input  wire logic               pop_i,
  output ctl_pkg::tok_t           head_o,
  output logic [2:0]              fill_o
);
  import ctl_pkg::*;

  tok_t [3:0] mem_q;
  logic [1:0] rd_q, wr_q;
  logic [2:0] fill_q;
  logic       pop;
  logic [2:0] add;

  assign valid_o = fill_q != 3'd0;
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign fill_o  = fill_q;
  // three free slots, counting the one drained this cycle
  assign space_o = (fill_q - {2'd0, pop}) <= 3'd1;
  assign add     = wr_i ? {1'b0, cnt_i} : 3'd0;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++)
      if (wr_i && 2'(i) < cnt_i) mem_q[wr_q + 2'(i)] <= tok_i[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; fill_q <= '0;
    end else begin
      wr_q   <= wr_q + add[1:0];
      rd_q   <= rd_q + {1'b0, pop};
      fill_q <= fill_q + add - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/config_text_lexer_top.sv =====
`default_nettype none
// Configuration text lexer.
// in_byte: one source byte per beat (data_byte, last). A zero byte or a
//   byte flagged last (after it is lexed) ends the text.
// out_tok: token beats (kind, error_code, start_offset, span_length,
//   line_number, last_result). Each byte yields 0..3 beats; last_result marks
//   the final beat of a byte.
// A taken byte's tokens land in a four-entry queue and are offered from the
// next cycle, one beat per cycle while out_tok.ready is high. Throughput is
// one byte per cycle while the queue drains; the input is held whenever the
// queue has fewer than three free entries, counting the beat leaving it.
// After an error or end of input the lexer halts and swallows bytes with no
// tokens until reset. Reset (rst_ni low) returns to the start of a text:
// line 1, offset 0, key mode, empty queue.
// When the receiver stalls, the queue fills and in_byte.ready drops; nothing
// is lost.
module config_text_lexer_top #(
  parameter int unsigned OFFSET_BITS     = 20,
  parameter int unsigned MAX_PAREN_DEPTH = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ctl_byte_if.sink  in_byte,
  ctl_tok_if.source out_tok
);
  import ctl_pkg::*;

  tok_t [2:0] toks;
  tok_t       head;
  logic [1:0] cnt;
  logic [2:0] fill;
  logic       space, step;

  assign in_byte.ready = space;
  assign step = in_byte.valid && space;

  ctl_core #(.OFFSET_BITS(OFFSET_BITS), .MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)) u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(in_byte.data_byte), .last_i(in_byte.last),
    .tok_o(toks), .cnt_o(cnt)
  );

  ctl_outq u_q (
    .clk_i, .rst_ni, .wr_i(step), .tok_i(toks), .cnt_i(cnt), .space_o(space),
    .valid_o(out_tok.valid), .pop_i(out_tok.ready), .head_o(head), .fill_o(fill)
  );

  assign out_tok.kind         = head.kind;
  assign out_tok.error_code   = head.error_code;
  assign out_tok.start_offset = head.start_offset;
  assign out_tok.span_length  = head.span_length;
  assign out_tok.line_number  = head.line_number;
  assign out_tok.last_result  = head.last_result;

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni) fill <= 3'd4)
    else $error("token queue overflow");
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tok.valid && out_tok.kind != K_ERROR |-> out_tok.error_code == E_NONE)
    else $error("error code on non-error token");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tok.valid && (out_tok.kind == K_ERROR || out_tok.kind == K_END)
      |-> out_tok.last_result)
    else $error("terminal token not last of its byte");
endmodule
`default_nettype wire

// ===== tb/config_text_lexer_tok_chk.sv =====
`timescale 1ns / 1ps
module config_text_lexer_tok_chk (
  input  logic clk_i,
  input  logic rst_ni,
  ctl_byte_if  in_mon,
  ctl_tok_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  import ctl_pkg::*;

  localparam logic [19:0] OFS_MAX   = '1;
  localparam int          DEPTH_MAX = 15;
  localparam logic [7:0]  CR  = 8'h0D;
  localparam logic [7:0]  LF  = 8'h0A;
  localparam logic [7:0]  TAB = 8'h09;

  string kw_s[4] = '{"include", {"include", "_shell"}, "global", "else"};
  int    kw_n[4] = '{7, 13, 6, 4};

  lex_mode_e   mode;
  pend_e       pend;
  int          depth;
  logic        in_cond, key_mode, esc, was_cr, halted_q;
  logic [3:0]  kw_live;
  logic [19:0] offs, tstart, cur_line, tline;

  tok_t res[3];
  int   nres;
  tok_t tok_q[$];

  function automatic logic [19:0] inc20(input logic [19:0] v);
    return (v == OFS_MAX) ? v : v + 20'd1;
  endfunction

  function automatic logic [19:0] span(input logic [19:0] e, input logic [19:0] s);
    return (e > s) ? e - s : 20'd0;
  endfunction

  function automatic logic letter_f(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_f(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic namech_f(input logic [7:0] c);
    return letter_f(c) || digit_f(c) || c == "." || c == "_" || c == "-";
  endfunction

  task put(input logic [4:0] k, input logic [3:0] e, input logic [19:0] s,
           input logic [19:0] sp, input logic [19:0] ln);
    if (nres < 3) begin
      res[nres] = '{kind: k, error_code: e, start_offset: s, span_length: sp,
                    line_number: ln, last_result: 1'b0};
      nres++;
    end
  endtask

  task tok_at(input logic [4:0] k, input logic [19:0] e);
    put(k, E_NONE, tstart, span(e, tstart), tline);
  endtask

  task raise(input logic [3:0] code, input logic [19:0] s, input logic [19:0] ln);
    put(K_ERROR, code, s, 20'd0, ln);
    halted_q = 1'b1;
    mode = M_IDLE;
    pend = P_NONE;
  endtask

  task count_line(input logic [7:0] c);
    if (!(c == LF && was_cr) && cur_line != LINE_SAT) cur_line++;
  endtask

  task kw_step(input logic [7:0] c, input logic [19:0] pos);
    int n;
    n = span(pos, tstart);
    for (int k = 0; k < 4; k++)
      if (kw_live[k] && (n >= kw_n[k] || kw_s[k][n] != c)) kw_live[k] = 1'b0;
  endtask

  task name_end(input logic [19:0] e);
    logic [4:0] k_out;
    logic       hit;
    k_out = K_LKEY;
    hit = 1'b0;
    for (int k = 0; k < 4; k++)
      if (!hit && kw_live[k] && span(e, tstart) == kw_n[k]) begin
        k_out = K_KW0 + 5'(k);
        hit = 1'b1;
      end
    tok_at(k_out, e);
    mode = M_IDLE;
  endtask

  task dispatch(input logic [7:0] c, input logic [19:0] pos);
    logic [19:0] nx;
    nx = inc20(pos);
    tstart = pos;
    tline = cur_line;
    case (c)
      "=": begin
        if (depth > 0 || in_cond) pend = P_EQ;
        else if (key_mode) tok_at(K_ASSIGN, nx);
        else raise(E_EQ_BARE, pos, cur_line);
      end
      "!": begin
        if (in_cond) pend = P_BANG;
        else raise(E_BANG_BARE, pos, cur_line);
      end
      "+": pend = P_PLUS;
      " ", TAB: ;
      CR, LF: begin
        count_line(c);
        if (depth == 0) mode = M_EOL;
      end
      ",": if (depth > 0) tok_at(K_COMMA, nx);
      "\"": begin
        mode = M_STR;
        esc = 1'b0;
      end
      "(": begin
        if (depth < DEPTH_MAX) depth++;
        tok_at(K_LPAREN, nx);
      end
      ")": begin
        if (depth > 0) depth--;
        tok_at(K_RPAREN, nx);
      end
      "$": begin
        in_cond = 1'b1;
        key_mode = 1'b0;
        tok_at(K_DOLLAR, nx);
      end
      "{": tok_at(K_LCURLY, nx);
      "}": tok_at(K_RCURLY, nx);
      "[": tok_at(K_LBRACKET, nx);
      "]": tok_at(K_RBRACKET, nx);
      "#": mode = M_CMT;
      default: begin
        if (in_cond) begin
          if (letter_f(c)) mode = M_CNAME;
          else raise(E_COND_CHAR, pos, cur_line);
        end else if (digit_f(c)) begin
          mode = M_INT;
        end else if (namech_f(c)) begin
          mode = M_NAME;
          kw_live = 4'hF;
          kw_step(c, pos);
        end else begin
          raise(E_NAME_CHAR, pos, cur_line);
        end
      end
    endcase
  endtask

  task lex_consume(input logic [7:0] c, input logic [19:0] pos);
    logic        again;
    pend_e       p;
    logic [19:0] nx;
    again = 1'b0;
    nx = inc20(pos);
    if (pend != P_NONE) begin
      p = pend;
      pend = P_NONE;
      if (p == P_PLUS) begin
        if (c == "=") begin
          tok_at(K_APPEND, nx);
          return;
        end
        put(K_PLUS, E_NONE, tstart, 20'd1, tline);
        again = 1'b1;
      end else if (p == P_EQ && depth > 0) begin
        if (c == ">") tok_at(K_ARRASSIGN, nx);
        else raise(E_EQ_PAREN, tstart, tline);
        return;
      end else begin
        if (c == "=") tok_at(p == P_EQ ? K_EQ : K_NE, nx);
        else if (c == "~") tok_at(p == P_EQ ? K_MATCH : K_NOMATCH, nx);
        else begin
          raise(p == P_EQ ? E_EQ_COND : E_BANG_COND, tstart, tline);
          return;
        end
        in_cond = 1'b0;
        key_mode = 1'b1;
        return;
      end
    end else begin
      case (mode)
        M_NAME: begin
          if (namech_f(c)) kw_step(c, pos);
          else begin
            name_end(pos);
            again = 1'b1;
          end
        end
        M_CNAME: if (!letter_f(c)) begin
          tok_at(K_CONDNAME, pos);
          mode = M_IDLE;
          again = 1'b1;
        end
        M_INT: if (!digit_f(c)) begin
          tok_at(K_INTEGER, pos);
          mode = M_IDLE;
          again = 1'b1;
        end
        M_STR: begin
          if (esc && c == "\"") esc = 1'b0;
          else begin
            esc = (c == "\\");
            if (c == "\"") begin
              tok_at(K_STRING, nx);
              mode = M_IDLE;
            end
          end
        end
        M_CMT: if (c == LF || c == CR) begin
          mode = M_IDLE;
          again = 1'b1;
        end
        M_EOL: begin
          if (c == LF || c == CR) count_line(c);
          else if (c == "#") mode = M_EOLCMT;
          else if (c != " " && c != TAB) begin
            tok_at(K_EOL, pos);
            key_mode = 1'b1;
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_EOLCMT: if (c == LF || c == CR) begin
          count_line(c);
          mode = M_EOL;
        end
        default: begin
          mode = M_IDLE;
          again = 1'b1;
        end
      endcase
    end
    if (again && !halted_q) dispatch(c, pos);
  endtask

  task finish_text(input logic [19:0] pos);
    if (pend == P_PLUS) put(K_PLUS, E_NONE, tstart, 20'd1, tline);
    else if (pend == P_EQ)
      raise(depth > 0 ? E_EQ_PAREN : (in_cond ? E_EQ_COND : E_EQ_BARE), tstart, tline);
    else if (pend == P_BANG) raise(in_cond ? E_BANG_COND : E_BANG_BARE, tstart, tline);
    else begin
      case (mode)
        M_NAME:  raise(E_NAME_CHAR, tstart, tline);
        M_CNAME: raise(E_COND_CHAR, tstart, tline);
        M_STR:   raise(E_OPEN_STR, tstart, tline);
        M_INT:   tok_at(K_INTEGER, pos);
        M_EOL, M_EOLCMT: begin
          tok_at(K_EOL, pos);
          key_mode = 1'b1;
        end
        default: ;
      endcase
    end
    if (!halted_q) put(K_END, E_NONE, pos, 20'd0, cur_line);
    halted_q = 1'b1;
    pend = P_NONE;
    mode = M_IDLE;
  endtask

  task lex_byte(input logic [7:0] c, input logic lst);
    nres = 0;
    if (halted_q) return;
    if (c == 8'd0) finish_text(offs);
    else begin
      lex_consume(c, offs);
      was_cr = (c == CR);
      offs = inc20(offs);
      if (lst && !halted_q) finish_text(offs);
    end
    if (nres > 0) res[nres-1].last_result = 1'b1;
    for (int i = 0; i < nres; i++) tok_q.push_back(res[i]);
  endtask

  task check_tok;
    tok_t e;
    if (tok_q.size() == 0) begin
      $error("token beat with nothing expected: kind %0d", out_mon.kind);
      fail_cnt_o++;
      return;
    end
    e = tok_q.pop_front();
    if (out_mon.kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, out_mon.kind);
      fail_cnt_o++;
    end
    if (out_mon.error_code !== e.error_code) begin
      $error("error_code: expected %0d, got %0d", e.error_code, out_mon.error_code);
      fail_cnt_o++;
    end
    if (out_mon.start_offset !== e.start_offset) begin
      $error("start_offset: expected %0d, got %0d", e.start_offset, out_mon.start_offset);
      fail_cnt_o++;
    end
    if (out_mon.span_length !== e.span_length) begin
      $error("span_length: expected %0d, got %0d", e.span_length, out_mon.span_length);
      fail_cnt_o++;
    end
    if (out_mon.line_number !== e.line_number) begin
      $error("line_number: expected %0d, got %0d", e.line_number, out_mon.line_number);
      fail_cnt_o++;
    end
    if (out_mon.last_result !== e.last_result) begin
      $error("last_result: expected %0d, got %0d", e.last_result, out_mon.last_result);
      fail_cnt_o++;
    end
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = M_IDLE;
      pend = P_NONE;
      depth = 0;
      in_cond = 1'b0;
      key_mode = 1'b1;
      kw_live = 4'hF;
      esc = 1'b0;
      offs = '0;
      tstart = '0;
      cur_line = 20'd1;
      tline = 20'd1;
      was_cr = 1'b0;
      halted_q = 1'b0;
      tok_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) lex_byte(in_mon.data_byte, in_mon.last);
      if (out_mon.valid && out_mon.ready) check_tok();
    end
    pending_o = tok_q.size();
  end

endmodule

// ===== tb/config_text_lexer_top_tb.sv =====
`timescale 1ns / 1ps
module config_text_lexer_top_tb;

  localparam logic [7:0] CR  = 8'h0D;
  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] TAB = 8'h09;
  localparam string NAME_CH =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";
  localparam string KW_TXT[4] = '{"include", {"include", "_shell"}, "global", "else"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  bit   hold_req = 1'b0;

  logic [8:0] text_q[$];  // {last, byte}

  ctl_byte_if bi ();
  ctl_tok_if  bo ();

  config_text_lexer_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_byte (bi),
    .out_tok (bo)
  );

  config_text_lexer_tok_chk chk_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (bi),
    .out_mon    (bo),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task add_ch(input logic [7:0] c);
    text_q.push_back({1'b0, c});
  endtask

  task add_s(input string s);
    for (int i = 0; i < s.len(); i++) add_ch(s[i]);
  endtask

  task add_ws;
    repeat ($urandom_range(0, 2)) add_ch($urandom_range(0, 1) ? " " : TAB);
  endtask

  task add_nl;
    case ($urandom_range(0, 2))
      0: add_ch(LF);
      1: begin
        add_ch(CR);
        add_ch(LF);
      end
      default: add_ch(CR);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        add_ws();
        add_ch("#");
        repeat ($urandom_range(0, 5)) add_ch($urandom_range(0, 1) ?
          8'($urandom_range(128, 255)) : 8'($urandom_range(32, 126)));
        add_ch(LF);
      end
      1: begin
        add_ch(" ");
        add_ch(LF);
      end
      default: ;
    endcase
  endtask

  task add_name;
    int k;
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: add_s(KW_TXT[k]);
      1: begin
        add_s(KW_TXT[k]);
        add_ch(NAME_CH[$urandom_range(0, 64)]);
      end
      default: begin
        add_ch($urandom_range(0, 1) ? NAME_CH[$urandom_range(0, 51)]
                                    : NAME_CH[$urandom_range(62, 64)]);
        repeat ($urandom_range(0, 5)) add_ch(NAME_CH[$urandom_range(0, 64)]);
      end
    endcase
  endtask

  task add_str;
    logic [7:0] c;
    add_ch("\"");
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: add_s("\\\"");
        1: add_ch(8'($urandom_range(128, 255)));
        2: add_ch(LF);
        default: begin
          c = 8'($urandom_range(32, 126));
          add_ch((c == "\"" || c == "\\") ? "q" : c);
        end
      endcase
    end
    add_ch("\"");
  endtask

  task add_int;
    repeat ($urandom_range(1, 5)) add_ch(8'($urandom_range(48, 57)));
  endtask

  task add_val(input bit nest);
    case ($urandom_range(0, nest ? 3 : 2))
      0: add_str();
      1: add_int();
      2: add_name();
      default: begin
        add_ch("(");
        repeat ($urandom_range(1, 3)) begin
          add_val(0);
          if ($urandom_range(0, 1)) begin
            add_s(" => ");
            add_val(0);
          end
          add_ch(",");
          if ($urandom_range(0, 3) == 0) add_ch($urandom_range(0, 1) ? LF : CR);
          add_ws();
        end
        add_ch(")");
      end
    endcase
  endtask

  task add_assign;
    add_name();
    add_ws();
    add_s($urandom_range(0, 2) ? "=" : "+=");
    add_ws();
    add_val(1);
    if ($urandom_range(0, 3) == 0) begin
      add_s(" + ");
      add_val(0);
    end
    add_nl();
  endtask

  task add_body;
    add_s(" {");
    add_nl();
    repeat ($urandom_range(1, 2)) add_assign();
    add_ch("}");
  endtask

  task add_cond;
    string ops[4];
    ops = '{"==", "=~", "!=", "!~"};
    add_ch("$");
    repeat ($urandom_range(1, 5)) add_ch(NAME_CH[$urandom_range(0, 51)]);
    add_ch("[");
    add_str();
    add_ch("]");
    add_ws();
    add_s(ops[$urandom_range(0, 3)]);
    add_ws();
    add_str();
    add_body();
    if ($urandom_range(0, 1)) begin
      add_s(" else");
      add_body();
    end
    add_nl();
  endtask

  task build_text;
    // opening directed stretch: block, CRLF, array with => and a comma
    add_s("global {");
    add_ch(CR);
    add_ch(LF);
    add_s("a=(1,\"b\"=>c)");
    add_ch(LF);
    add_ch("}");
    add_ch(LF);
    while (text_q.size() < 470) begin
      case ($urandom_range(0, 6))
        0, 1, 2: add_assign();
        3: add_cond();
        4: begin
          if ($urandom_range(0, 1)) add_s("include ");
          else begin
            add_s("include");
            add_s("_shell ");
          end
          add_str();
          add_nl();
        end
        5: begin
          add_s("global");
          add_body();
          add_nl();
        end
        default: begin
          add_s("# note");
          add_ch(8'($urandom_range(128, 255)));
          add_nl();
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0: add_ch(8'd0);
      1: text_q[$][8] = 1'b1;
      2: begin
        if ($urandom_range(0, 1)) add_s("x = 1 !");
        else begin
          add_s("k");
          add_ch(8'hC8);
        end
      end
      default: begin
        add_s("n = 42");
        text_q[$][8] = 1'b1;
      end
    endcase
    // halted from here on: these bytes are swallowed
    repeat (6) text_q.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
  endtask

  // receiver
  initial begin
    int  s;
    bit  calm;
    calm = 1'b0;
    bo.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 40) == 0) calm = !calm;
      s = calm ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        bo.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (s > 0) begin
        bo.ready <= 1'b0;
        repeat (s) @(negedge clk_i);
      end
      bo.ready <= 1'b1;
      do @(posedge clk_i); while (!bo.valid);
      @(negedge clk_i);
    end
  end

  // sender
  initial begin
    int  gap;
    bit  calm;
    calm = 1'b0;
    bi.valid = 1'b0;
    bi.data_byte = 8'd0;
    bi.last = 1'b0;
    build_text();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < text_q.size(); i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 350) begin
        bi.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      if ($urandom_range(0, 50) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        bi.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      bi.valid <= 1'b1;
      bi.data_byte <= text_q[i][7:0];
      bi.last <= text_q[i][8];
      do @(posedge clk_i); while (!bi.ready);
      @(negedge clk_i);
    end
    bi.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== config_text_lexer_top.f =====
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_byte_if.sv
hw/rtl/ctl_tok_if.sv
hw/rtl/ctl_core.sv
hw/rtl/ctl_outq.sv
hw/rtl/config_text_lexer_top.sv
tb/config_text_lexer_tok_chk.sv
tb/config_text_lexer_top_tb.sv
